@@ design/circular_queue_with_search_unit_defines.svh @@
// assertion macros for the circular queue with search unit
// expects clk_i and rst_ni in the scope that uses them
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_UNIT_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CQS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cqs assertion failed");
`define CQS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cqs assertion failed");
`define CQS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cqs assertion failed");
`else
`define CQS_ASSERT(lbl, prop)
`define CQS_ASSERT_IMPL(lbl, ante, cons)
`define CQS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/cqs_pkg.sv @@
// types and constants shared by the circular queue with search unit
// no dependencies
package cqs_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cqs_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED
  } cqs_state_e;

  // command broadcast to every cell
  typedef struct packed {
    logic accept;
    logic push;
    logic pop;
    logic search;
    logic clear;
  } cqs_cmd_t;

endpackage

@@ design/cqs_ifs.sv @@
// valid/ready channel interfaces: input items, result items, capacity writes
// depends on cqs_pkg
interface cqs_in_if;
  logic                              valid;
  logic                              ready;
  logic [cqs_pkg::OP_W-1:0]          operation;
  logic signed [cqs_pkg::DATA_W-1:0] value;
  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

interface cqs_out_if;
  logic                              valid;
  logic                              ready;
  logic [cqs_pkg::ST_W-1:0]          status;
  logic                              found;
  logic signed [cqs_pkg::DATA_W-1:0] head_value;
  logic signed [cqs_pkg::DATA_W-1:0] tail_value;
  logic [cqs_pkg::CAP_W-1:0]         count;
  modport source (output valid, output status, output found, output head_value,
                  output tail_value, output count, input ready);
  modport sink (input valid, input status, input found, input head_value,
                input tail_value, input count, output ready);
endinterface

interface cqs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cqs_pkg::CAP_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/cqs_cell.sv @@
// one queue slot: holds a word and its valid flag, shifts toward the head on pop
// depends on cqs_pkg
module cqs_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cqs_pkg::cqs_cmd_t          cmd_i,
  input  logic [CW-1:0]              count_i,
  input  logic [cqs_pkg::DATA_W-1:0] value_i,
  input  logic [cqs_pkg::DATA_W-1:0] nxt_data_i,
  input  logic                       nxt_valid_i,
  output logic [cqs_pkg::DATA_W-1:0] data_o,
  output logic                       valid_o,
  output logic                       hit_o
);

  logic [cqs_pkg::DATA_W-1:0] data_q, data_d;
  logic                       valid_q, valid_d;
  logic                       hit_q, hit_d;
  logic                       wr_here;

  assign wr_here = cmd_i.push && (count_i == CW'(IDX));

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    hit_d   = hit_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.pop) begin
      data_d  = nxt_data_i;
      valid_d = nxt_valid_i;
    end else if (wr_here) begin
      data_d  = value_i;
      valid_d = 1'b1;
    end
    // compare against the contents before this beat
    if (cmd_i.accept) begin
      hit_d = cmd_i.search && valid_q && (data_q == value_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule

@@ design/cqs_reduce.sv @@
// two-level or tree over the cell hit flags, first level registered
// no dependencies
module cqs_reduce #(
  parameter int N = 16
) (
  input  logic         clk_i,
  input  logic [N-1:0] hit_i,
  output logic         any_o
);

  localparam int G  = 16;
  localparam int NG = (N + G - 1) / G;

  logic [NG*G-1:0] hit_pad;
  logic [NG-1:0]   grp_d, grp_q;

  assign hit_pad = (NG*G)'(hit_i);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = |hit_pad[g*G +: G];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign any_o = |grp_q;

endmodule

@@ design/circular_queue_with_search_unit.sv @@
// circular queue with search: input passes cell hit, group or and output registers
// one item at a time: cell compare, registered group or, final or into output
// a finished result waits in the output register while the next item runs
// reset: queue empty, capacity 16, no clearing pass
// depends on cqs_pkg, cqs_ifs, cqs_cell, cqs_reduce and the defines header
`include "circular_queue_with_search_unit_defines.svh"
module circular_queue_with_search_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cqs_cfg_if.sink     cfg_i,
  cqs_in_if.sink      in_i,
  cqs_out_if.source   out_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > cqs_pkg::CAP_W) ? CW : cqs_pkg::CAP_W;

  cqs_pkg::cqs_state_e state_q, state_d;

  logic [cqs_pkg::CAP_W-1:0]  cap_q;
  logic [XW-1:0]              cap_x;
  logic [CW-1:0]              cap_eff;
  logic [CW-1:0]              count_q, count_d;
  logic [cqs_pkg::DATA_W-1:0] tail_q, tail_d;
  logic [cqs_pkg::ST_W-1:0]   status_q, status_d;
  logic [cqs_pkg::OP_W-1:0]   op_q;

  logic                       accept, cfg_wr, full, empty, out_load, any_hit;
  cqs_pkg::cqs_cmd_t          cmd;

  logic [cqs_pkg::DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]           cell_valid;
  logic [DEPTH-1:0]           cell_hit;

  logic                       ov_q;
  logic [cqs_pkg::ST_W-1:0]   o_status_q;
  logic                       o_found_q;
  logic [cqs_pkg::DATA_W-1:0] o_head_q, o_tail_q;
  logic [cqs_pkg::CAP_W-1:0]  o_count_q;

  // capacity clamped to 1..DEPTH
  assign cap_x = XW'(cap_q);
  always_comb begin
    if (cap_x == '0) begin
      cap_eff = CW'(1);
    end else if (cap_x > XW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = cap_x[CW-1:0];
    end
  end

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;
  assign in_i.ready  = (state_q == cqs_pkg::S_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign full        = (count_q >= cap_eff);
  assign empty       = (count_q == '0);

  always_comb begin
    cmd        = '0;
    cmd.accept = accept;
    cmd.clear  = cfg_wr;
    cmd.push   = accept && (in_i.operation == cqs_pkg::OP_PUSH) && !full;
    cmd.pop    = accept && (in_i.operation == cqs_pkg::OP_POP) && !empty;
    cmd.search = accept && (in_i.operation == cqs_pkg::OP_SEARCH);
  end

  always_comb begin
    status_d = cqs_pkg::ST_OK;
    if (in_i.operation == cqs_pkg::OP_PUSH && full) begin
      status_d = cqs_pkg::ST_FULL;
    end else if (in_i.operation == cqs_pkg::OP_POP && empty) begin
      status_d = cqs_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    count_d = count_q;
    tail_d  = tail_q;
    if (cmd.clear) begin
      count_d = '0;
    end else if (cmd.push) begin
      count_d = count_q + CW'(1);
      tail_d  = in_i.value;
    end else if (cmd.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  // row of cells, cell 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [cqs_pkg::DATA_W-1:0] nxt_data;
    logic                       nxt_valid;
    if (i == DEPTH - 1) begin : g_last
      assign nxt_data  = '0;
      assign nxt_valid = 1'b0;
    end else begin : g_mid
      assign nxt_data  = cell_data[i+1];
      assign nxt_valid = cell_valid[i+1];
    end
    cqs_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .count_i     (count_q),
      .value_i     (in_i.value),
      .nxt_data_i  (nxt_data),
      .nxt_valid_i (nxt_valid),
      .data_o      (cell_data[i]),
      .valid_o     (cell_valid[i]),
      .hit_o       (cell_hit[i])
    );
  end

  cqs_reduce #(
    .N (DEPTH)
  ) u_reduce (
    .clk_i (clk_i),
    .hit_i (cell_hit),
    .any_o (any_hit)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cqs_pkg::S_IDLE: if (accept) state_d = cqs_pkg::S_CMP;
      cqs_pkg::S_CMP:  state_d = cqs_pkg::S_RED;
      cqs_pkg::S_RED:  if (out_load) state_d = cqs_pkg::S_IDLE;
      default:         state_d = cqs_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    out_load = 1'b0;
    unique case (state_q)
      cqs_pkg::S_RED: out_load = !ov_q || out_o.ready;
      default:        out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cqs_pkg::S_IDLE;
      cap_q   <= cqs_pkg::CAP_RESET;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_wr) begin
        cap_q <= cfg_i.data;
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
    if (accept) begin
      status_q <= status_d;
      op_q     <= in_i.operation;
    end
    if (out_load) begin
      o_status_q <= status_q;
      o_found_q  <= (op_q == cqs_pkg::OP_SEARCH) && any_hit;
      o_head_q   <= empty ? '0 : cell_data[0];
      o_tail_q   <= empty ? '0 : tail_q;
      o_count_q  <= cqs_pkg::CAP_W'(count_q);
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.status     = o_status_q;
  assign out_o.found      = o_found_q;
  assign out_o.head_value = o_head_q;
  assign out_o.tail_value = o_tail_q;
  assign out_o.count      = o_count_q;

  `CQS_ASSERT(a_count_le_cap, count_q <= cap_eff)
  `CQS_ASSERT(a_valid_matches_count, $countones(cell_valid) == 32'(count_q))
  `CQS_ASSERT_NEXT(a_push_grows, cmd.push && !cmd.clear, count_q == $past(count_q) + CW'(1))
  `CQS_ASSERT_IMPL(a_found_is_ok, ov_q && o_found_q, o_status_q == cqs_pkg::ST_OK)
  `CQS_ASSERT_IMPL(a_empty_zero, ov_q && o_count_q == '0, o_head_q == '0 && o_tail_q == '0)

endmodule

@@ test/cqs_result_checker.sv @@
`timescale 1ns / 100ps
// result checker for the circular queue with search unit: watches the capacity,
// input and result channels, predicts every result and compares field by field
// depends on cqs_pkg and the channel interfaces in cqs_ifs
module cqs_result_checker
  import cqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  cqs_cfg_if   cfg_i,
  cqs_in_if    in_i,
  cqs_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct {
    cqs_status_e               status;
    logic                      found;
    logic signed [DATA_W-1:0]  head_value;
    logic signed [DATA_W-1:0]  tail_value;
    logic [CAP_W-1:0]          count;
  } queue_result_t;

  logic [DATA_W-1:0] slot_q [DEPTH];
  int unsigned       head_idx;
  int unsigned       tail_idx;
  int unsigned       held;
  logic [CAP_W-1:0]  capacity_reg;
  queue_result_t     expected_q [$];

  // register value clamped to 1..DEPTH
  function automatic int unsigned slots_in_use();
    if (capacity_reg == '0) return 1;
    if (capacity_reg > DEPTH) return DEPTH;
    return 32'(capacity_reg);
  endfunction

  function automatic int unsigned wrap_next(input int unsigned idx);
    return (idx + 1 >= slots_in_use()) ? 0 : idx + 1;
  endfunction

  function automatic void empty_queue();
    head_idx = 0;
    tail_idx = slots_in_use() - 1;
    held     = 0;
  endfunction

  function automatic queue_result_t apply_item(input logic [OP_W-1:0] op,
                                               input logic [DATA_W-1:0] val);
    queue_result_t res;
    int unsigned   idx;
    res.status = ST_OK;
    res.found  = 1'b0;
    case (op)
      OP_PUSH: begin
        if (held >= slots_in_use()) begin
          res.status = ST_FULL;
        end else begin
          tail_idx         = wrap_next(tail_idx);
          slot_q[tail_idx] = val;
          held++;
        end
      end
      OP_POP: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          head_idx = wrap_next(head_idx);
          held--;
        end
      end
      OP_SEARCH: begin
        // walk every live entry from head to tail, across the wrap
        idx = head_idx;
        for (int k = 0; k < held; k++) begin
          if (slot_q[idx] == val) res.found = 1'b1;
          idx = wrap_next(idx);
        end
      end
      default: ;
    endcase
    res.head_value = (held == 0) ? '0 : slot_q[head_idx];
    res.tail_value = (held == 0) ? '0 : slot_q[tail_idx];
    res.count      = held[CAP_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    if (!rst_ni) begin
      capacity_reg = CAP_RESET;
      empty_queue();
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no prediction pending");
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (out_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_i.status);
            fail_count_o++;
          end
          if (out_i.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_i.found);
            fail_count_o++;
          end
          if (out_i.head_value !== want.head_value) begin
            $error("head_value: expected %0d, actual %0d", want.head_value,
                   out_i.head_value);
            fail_count_o++;
          end
          if (out_i.tail_value !== want.tail_value) begin
            $error("tail_value: expected %0d, actual %0d", want.tail_value,
                   out_i.tail_value);
            fail_count_o++;
          end
          if (out_i.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, out_i.count);
            fail_count_o++;
          end
        end
      end
      // a capacity write empties the queue
      if (cfg_i.valid && cfg_i.ready) begin
        capacity_reg = cfg_i.data;
        empty_queue();
      end
      if (in_i.valid && in_i.ready) begin
        expected_q.push_back(apply_item(in_i.operation, in_i.value));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// top of the circular queue with search testbench: clock, reset, stimulus, verdict
// depends on cqs_pkg, cqs_ifs, the unit itself and cqs_result_checker
module tb_top;
  import cqs_pkg::*;

  localparam int               DEPTH      = 16;
  localparam int               IDLE_LIMIT = 1000;
  localparam int               PHASES     = 9;
  localparam int               PHASE_LEN  = 100;
  localparam logic [OP_W-1:0]  OP_NOP     = 2'd3;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   tx_idle_on;
  bit   rx_idle_on;

  logic [DATA_W-1:0] pushed_hist [$];
  logic [CAP_W-1:0]  phase_caps [PHASES] = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd2,
                                            5'd17, 5'd7, 5'd5};

  cqs_cfg_if cfg_ch ();
  cqs_in_if  in_ch ();
  cqs_out_if out_ch ();

  circular_queue_with_search_unit #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  cqs_result_checker #(.DEPTH(DEPTH)) queue_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_i        (cfg_ch),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ends the run when no channel moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall before each beat while rx_idle_on is set
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4, 5:    return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // called at a clock edge; leaves valid high after the accepting edge
  task automatic issue(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= val;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_PUSH) begin
      pushed_hist.push_back(val);
      if (pushed_hist.size() > 32) void'(pushed_hist.pop_front());
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    // let the pipeline settle past its latency
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    pushed_hist.delete();
  endtask

  initial begin
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] val;
    int                pick;
    int                push_pct;
    rst_n           = 1'b0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_PUSH;
    in_ch.value     = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = CAP_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity: empty cases, field extremes, unused code
    issue(OP_POP, '0);
    issue(OP_SEARCH, '0);
    issue(OP_NOP, $urandom);
    issue(OP_PUSH, 32'h7fff_ffff);
    issue(OP_PUSH, 32'h8000_0000);
    issue(OP_PUSH, '0);
    issue(OP_PUSH, '1);
    issue(OP_SEARCH, 32'h8000_0000);
    issue(OP_POP, '0);

    // two slots: full, wrap, search across the wrap, popped value gone
    write_capacity(5'd2);
    issue(OP_PUSH, 32'd11);
    issue(OP_PUSH, 32'd22);
    issue(OP_PUSH, 32'd33);
    issue(OP_SEARCH, 32'd22);
    issue(OP_POP, '0);
    issue(OP_PUSH, 32'd44);
    issue(OP_SEARCH, 32'd11);
    issue(OP_SEARCH, 32'd44);
    issue(OP_POP, '0);
    issue(OP_POP, '0);
    issue(OP_POP, '0);

    // zero capacity behaves as one slot
    write_capacity(5'd0);
    issue(OP_PUSH, 32'd55);
    issue(OP_PUSH, 32'd66);
    issue(OP_SEARCH, 32'd55);
    issue(OP_POP, '0);
    issue(OP_POP, '0);

    phase_caps[PHASES-1] = CAP_W'($urandom_range(0, 31));
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_caps[ph]);
      tx_idle_on = (ph % 4) != 1;
      rx_idle_on = (ph % 4) != 2 && (ph % 4) != 1;
      push_pct   = 30 + 20 * (ph % 3);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (ph == 4 && n == PHASE_LEN / 2) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 4) op = OP_NOP;
        else if (pick < 24) op = OP_SEARCH;
        else if ($urandom_range(0, 99) < push_pct) op = OP_PUSH;
        else op = OP_POP;
        if (op == OP_SEARCH && pushed_hist.size() > 0 && $urandom_range(0, 2) != 0)
          val = pushed_hist[$urandom_range(0, pushed_hist.size() - 1)];
        else
          val = rand_word();
        issue(op, val);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/cqs_pkg.sv
design/cqs_ifs.sv
design/cqs_cell.sv
design/cqs_reduce.sv
design/circular_queue_with_search_unit.sv
test/cqs_result_checker.sv
test/tb_top.sv
